// ----- rtl/core/bis_pkg.sv -----
// Shared types and constants of the bilinear intensity sampler.
// No dependencies; imported by the sampler, its blend unit and its checker.
package bis_pkg;

    localparam int ADDR_W      = 16;
    localparam int SUM_W       = 10;
    localparam int COORD_W     = 17;
    localparam int CFG_W       = 9;
    localparam int IDX_W       = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int ONE_Q16     = 65536;
    localparam int CHAN_FULL   = 765;
    localparam int ROUND_ADD   = 765 * 32768;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_765   = (1 << 26) / 765;
    localparam int CFG_RESET   = 256;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    // Neighbor read order: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
    typedef enum logic [1:0] {
        PH_00 = 2'd0,
        PH_10 = 2'd1,
        PH_01 = 2'd2,
        PH_11 = 2'd3
    } phase_t;

    typedef struct packed {
        logic [SUM_W-1:0]   s00;
        logic [SUM_W-1:0]   s10;
        logic [SUM_W-1:0]   s01;
        logic [SUM_W-1:0]   s11;
        logic [COORD_W-1:0] wu;
        logic [COORD_W-1:0] wv;
    } bis_sample_t;

endpackage

// ----- rtl/core/bilinear_intensity_sampler.sv -----
// Bilinear intensity sampler: top level with the pixel store, the address pipeline
// and the read sequencer. Depends on bis_pkg and bis_blend.
//
// Usage:
//   Input channel (s_*): one item per handshake. s_kind selects a pixel write
//   (s_pixel_index, s_red, s_green, s_blue) or a sample query (s_u_coord,
//   s_v_coord in Q0.16). A write gives no result; a query gives one result.
//   Result channel (m_*): m_intensity in Q0.16, 65536 is full white.
//   Config port: cfg_wr_en writes cfg_wdata to image_width (index 0) or
//   image_height (index 1); other indexes are ignored. Write only while idle.
//   Throughput: a query holds the single-port pixel store for one read per
//   neighbor, and the next item waits at the store port until those reads
//   are done; writes use one store access each and run at one per cycle
//   while no query holds the store.
//   Stall: results queue in a 4-entry output queue. Queries in flight are
//   counted against it; a query that finds it full stalls the input.
//   Reset: pipeline and queue empty, width and height back to 256. The pixel
//   store is not cleared; entries read before being written are undefined.
module bilinear_intensity_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bis_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bis_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [bis_pkg::ADDR_W-1:0]    s_pixel_index,
    input  logic [7:0]                    s_red,
    input  logic [7:0]                    s_green,
    input  logic [7:0]                    s_blue,
    input  logic [bis_pkg::COORD_W-1:0]   s_u_coord,
    input  logic [bis_pkg::COORD_W-1:0]   s_v_coord,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bis_pkg::COORD_W-1:0]   m_intensity
);
    import bis_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WCMP  = (WW > CFG_W) ? WW : CFG_W;
    localparam int HCMP  = (HW > CFG_W) ? HW : CFG_W;
    localparam int PW    = WW + COORD_W;
    localparam int PH    = HW + COORD_W;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration
    logic [CFG_W-1:0]   cfg_width_reg, cfg_height_reg;
    logic [WCMP-1:0]    w_cfg_ext;
    logic [HCMP-1:0]    h_cfg_ext;
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;

    // Address pipeline
    logic               p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic               p1_kind_reg, p2_kind_reg, p3_kind_reg, p4_kind_reg;
    logic [ADDR_W-1:0]  p1_idx_reg, p2_idx_reg, p3_idx_reg, p4_idx_reg;
    logic [SUM_W-1:0]   p1_sum_reg, p2_sum_reg, p3_sum_reg, p4_sum_reg;
    logic [COORD_W-1:0] p1_u_reg, p1_v_reg;
    logic [PW-1:0]      p2_prod_u_reg;
    logic [PH-1:0]      p2_prod_v_reg;
    logic [XW-1:0]      p3_x0_reg, p3_x1_reg, p4_x0_reg, p4_x1_reg;
    logic [YW-1:0]      p3_y0_reg, p3_y1_reg;
    logic [COORD_W-1:0] p3_wu_reg, p3_wv_reg, p4_wu_reg, p4_wv_reg;
    logic [ADDR_W-1:0]  p4_rb0_reg, p4_rb1_reg;

    logic [PW-1:0]      prod_u;
    logic [PH-1:0]      prod_v;
    logic [WW:0]        ip_u, ip_u1, last_u, a_u, b_u;
    logic [HW:0]        ip_v, ip_v1, last_v, a_v, b_v;
    logic [PW-1:0]      off_u;
    logic [PH-1:0]      off_v;
    logic [COORD_W-1:0] wu_next, wv_next;
    logic [YW+WW-1:0]   rb0_full, rb1_full;

    // Store port stage
    logic               port_valid_reg, port_valid_next;
    logic               port_kind_reg;
    logic [ADDR_W-1:0]  port_idx_reg, port_rb0_reg, port_rb1_reg;
    logic [SUM_W-1:0]   port_sum_reg;
    logic [XW-1:0]      port_x0_reg, port_x1_reg;
    logic [COORD_W-1:0] port_wu_reg, port_wv_reg;
    phase_t             phase_reg, phase_next;
    logic               port_done, port_take, credit_ok, adv;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;

    logic [SUM_W-1:0]   pixel_mem [2**ADDR_W];
    logic [SUM_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;
    phase_t             rd_phase_reg;
    logic [COORD_W-1:0] rd_wu_reg, rd_wv_reg;
    logic [SUM_W-1:0]   s00_reg, s10_reg, s01_reg;

    bis_sample_t        sample;
    logic               blend_valid;
    logic [COORD_W-1:0] blend_intensity;

    // Output queue and credits
    logic [COORD_W-1:0] fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [CNT_W-1:0]   credit_reg, credit_next;
    logic               pop, take_query;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= CFG_W'(CFG_RESET);
            cfg_height_reg <= CFG_W'(CFG_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg_ext = WCMP'(cfg_width_reg);
        h_cfg_ext = HCMP'(cfg_height_reg);
        if (cfg_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (w_cfg_ext > WCMP'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(w_cfg_ext);
        end
        if (cfg_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (h_cfg_ext > HCMP'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(h_cfg_ext);
        end
    end

    // Handshake and sequencing
    always_comb begin
        port_done  = port_valid_reg && (port_kind_reg == KIND_WRITE || phase_reg == PH_11);
        credit_ok  = credit_reg < CNT_W'(FIFO_DEPTH);
        port_take  = p4_valid_reg && (!port_valid_reg || port_done)
                     && (p4_kind_reg == KIND_WRITE || credit_ok);
        adv        = !p4_valid_reg || port_take;
        take_query = port_take && p4_kind_reg == KIND_QUERY;
        pop        = m_valid && m_ready;
        if (port_take) begin
            port_valid_next = 1'b1;
        end else if (port_done) begin
            port_valid_next = 1'b0;
        end else begin
            port_valid_next = port_valid_reg;
        end
    end

    assign s_ready = adv;

    // Axis math
    always_comb begin
        prod_u = {{COORD_W{1'b0}}, w_eff} * {{WW{1'b0}}, p1_u_reg};
        prod_v = {{COORD_W{1'b0}}, h_eff} * {{HW{1'b0}}, p1_v_reg};

        ip_u   = p2_prod_u_reg[PW-1:16];
        ip_u1  = ip_u + (WW+1)'(1);
        last_u = {1'b0, w_eff} - (WW+1)'(1);
        a_u    = (ip_u > last_u) ? last_u : ip_u;
        b_u    = (ip_u1 > last_u) ? last_u : ip_u1;
        off_u  = p2_prod_u_reg - {a_u, 16'h0000};
        wu_next = (off_u > PW'(ONE_Q16)) ? COORD_W'(ONE_Q16) : COORD_W'(off_u);

        ip_v   = p2_prod_v_reg[PH-1:16];
        ip_v1  = ip_v + (HW+1)'(1);
        last_v = {1'b0, h_eff} - (HW+1)'(1);
        a_v    = (ip_v > last_v) ? last_v : ip_v;
        b_v    = (ip_v1 > last_v) ? last_v : ip_v1;
        off_v  = p2_prod_v_reg - {a_v, 16'h0000};
        wv_next = (off_v > PH'(ONE_Q16)) ? COORD_W'(ONE_Q16) : COORD_W'(off_v);

        rb0_full = {{WW{1'b0}}, p3_y0_reg} * {{YW{1'b0}}, w_eff};
        rb1_full = {{WW{1'b0}}, p3_y1_reg} * {{YW{1'b0}}, w_eff};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= s_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_kind_reg   <= s_kind;
            p1_idx_reg    <= s_pixel_index;
            p1_sum_reg    <= SUM_W'(s_red) + SUM_W'(s_green) + SUM_W'(s_blue);
            p1_u_reg      <= s_u_coord;
            p1_v_reg      <= s_v_coord;

            p2_kind_reg   <= p1_kind_reg;
            p2_idx_reg    <= p1_idx_reg;
            p2_sum_reg    <= p1_sum_reg;
            p2_prod_u_reg <= prod_u;
            p2_prod_v_reg <= prod_v;

            p3_kind_reg   <= p2_kind_reg;
            p3_idx_reg    <= p2_idx_reg;
            p3_sum_reg    <= p2_sum_reg;
            p3_x0_reg     <= XW'(a_u);
            p3_x1_reg     <= XW'(b_u);
            p3_y0_reg     <= YW'(a_v);
            p3_y1_reg     <= YW'(b_v);
            p3_wu_reg     <= wu_next;
            p3_wv_reg     <= wv_next;

            p4_kind_reg   <= p3_kind_reg;
            p4_idx_reg    <= p3_idx_reg;
            p4_sum_reg    <= p3_sum_reg;
            p4_x0_reg     <= p3_x0_reg;
            p4_x1_reg     <= p3_x1_reg;
            p4_wu_reg     <= p3_wu_reg;
            p4_wv_reg     <= p3_wv_reg;
            p4_rb0_reg    <= ADDR_W'(rb0_full);
            p4_rb1_reg    <= ADDR_W'(rb1_full);
        end
    end

    // Read sequencer: next phase
    always_comb begin
        phase_next = phase_reg;
        if (port_take) begin
            phase_next = PH_00;
        end else if (port_valid_reg && port_kind_reg == KIND_QUERY) begin
            case (phase_reg)
                PH_00:   phase_next = PH_10;
                PH_10:   phase_next = PH_01;
                PH_01:   phase_next = PH_11;
                default: phase_next = PH_11;
            endcase
        end
    end

    // Read sequencer: store port drive
    always_comb begin
        mem_we = port_valid_reg && port_kind_reg == KIND_WRITE;
        if (port_kind_reg == KIND_WRITE) begin
            mem_addr = port_idx_reg;
        end else begin
            case (phase_reg)
                PH_00:   mem_addr = port_rb0_reg + ADDR_W'(port_x0_reg);
                PH_10:   mem_addr = port_rb0_reg + ADDR_W'(port_x1_reg);
                PH_01:   mem_addr = port_rb1_reg + ADDR_W'(port_x0_reg);
                default: mem_addr = port_rb1_reg + ADDR_W'(port_x1_reg);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_valid_reg <= 1'b0;
            phase_reg      <= PH_00;
            rd_valid_reg   <= 1'b0;
        end else begin
            port_valid_reg <= port_valid_next;
            phase_reg      <= phase_next;
            rd_valid_reg   <= port_valid_reg && port_kind_reg == KIND_QUERY;
        end
    end

    always_ff @(posedge aclk) begin
        if (port_take) begin
            port_kind_reg <= p4_kind_reg;
            port_idx_reg  <= p4_idx_reg;
            port_sum_reg  <= p4_sum_reg;
            port_rb0_reg  <= p4_rb0_reg;
            port_rb1_reg  <= p4_rb1_reg;
            port_x0_reg   <= p4_x0_reg;
            port_x1_reg   <= p4_x1_reg;
            port_wu_reg   <= p4_wu_reg;
            port_wv_reg   <= p4_wv_reg;
        end
        rd_phase_reg <= phase_reg;
        rd_wu_reg    <= port_wu_reg;
        rd_wv_reg    <= port_wv_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pixel_mem[mem_addr] <= port_sum_reg;
        end
        rd_data_reg <= pixel_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            case (rd_phase_reg)
                PH_00:   s00_reg <= rd_data_reg;
                PH_10:   s10_reg <= rd_data_reg;
                PH_01:   s01_reg <= rd_data_reg;
                default: ;
            endcase
        end
    end

    always_comb begin
        sample.s00 = s00_reg;
        sample.s10 = s10_reg;
        sample.s01 = s01_reg;
        sample.s11 = rd_data_reg;
        sample.wu  = rd_wu_reg;
        sample.wv  = rd_wv_reg;
    end

    bis_blend u_blend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (rd_valid_reg && rd_phase_reg == PH_11),
        .in_sample     (sample),
        .out_valid     (blend_valid),
        .out_intensity (blend_intensity)
    );

    // Output queue
    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (blend_valid && !pop) begin
            fifo_cnt_next = fifo_cnt_reg + CNT_W'(1);
        end else if (!blend_valid && pop) begin
            fifo_cnt_next = fifo_cnt_reg - CNT_W'(1);
        end
        credit_next = credit_reg;
        if (take_query && !pop) begin
            credit_next = credit_reg + CNT_W'(1);
        end else if (!take_query && pop) begin
            credit_next = credit_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_next;
            credit_reg   <= credit_next;
            if (blend_valid) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (blend_valid) begin
            fifo_mem_reg[wr_ptr_reg] <= blend_intensity;
        end
    end

    assign m_valid     = fifo_cnt_reg != '0;
    assign m_intensity = fifo_mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/bis_blend.sv -----
// Bilinear blend of four channel sums into a Q0.16 intensity, four register stages.
// Depends on bis_pkg for the sample struct and the scaling constants.
module bis_blend (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  bis_pkg::bis_sample_t         in_sample,
    output logic                         out_valid,
    output logic [bis_pkg::COORD_W-1:0]  out_intensity
);
    import bis_pkg::*;

    localparam int TOP_W  = SUM_W + 16;
    localparam int P1_W   = SUM_W + COORD_W + 2;
    localparam int P2_W   = TOP_W + COORD_W + 2;
    localparam int ACC_W  = TOP_W + 16;
    localparam int Q_W    = ACC_W - 16;
    localparam int PROD_W = Q_W + COORD_W;
    localparam int REM_W  = SUM_W + 1;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [TOP_W-1:0]         top_reg, bot_reg;
    logic [COORD_W-1:0]       wv_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [Q_W-1:0]           q_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [COORD_W-1:0]       qe_reg;
    logic [REM_W-1:0]         rem_reg;

    logic signed [SUM_W:0]    du_top, du_bot;
    logic signed [P1_W-1:0]   pu_top, pu_bot, top_sum, bot_sum;
    logic signed [TOP_W:0]    dv;
    logic signed [P2_W-1:0]   pv, acc_sum;
    logic [TOP_W-1:0]         top_next, bot_next;
    logic [ACC_W-1:0]         acc_next;
    logic [Q_W-1:0]           q_next;
    logic [PROD_W-1:0]        prod_next;
    logic [COORD_W-1:0]       qe_next;
    logic [Q_W:0]             rem_full;
    logic [COORD_W-1:0]       res;

    always_comb begin
        du_top   = $signed({1'b0, in_sample.s10}) - $signed({1'b0, in_sample.s00});
        du_bot   = $signed({1'b0, in_sample.s11}) - $signed({1'b0, in_sample.s01});
        pu_top   = du_top * $signed({1'b0, in_sample.wu});
        pu_bot   = du_bot * $signed({1'b0, in_sample.wu});
        top_sum  = $signed({3'b000, in_sample.s00, 16'h0000}) + pu_top;
        bot_sum  = $signed({3'b000, in_sample.s01, 16'h0000}) + pu_bot;
        top_next = top_sum[TOP_W-1:0];
        bot_next = bot_sum[TOP_W-1:0];
    end

    always_comb begin
        dv       = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
        pv       = dv * $signed({1'b0, wv_reg});
        acc_sum  = $signed({3'b000, top_reg, 16'h0000}) + pv + $signed(P2_W'(ROUND_ADD));
        acc_next = acc_sum[ACC_W-1:0];
    end

    always_comb begin
        q_next    = acc_reg[ACC_W-1:16];
        prod_next = {{COORD_W{1'b0}}, q_next} * {{Q_W{1'b0}}, COORD_W'(RECIP_765)};
        qe_next   = prod_reg[RECIP_SHIFT +: COORD_W];
        rem_full  = {1'b0, q_reg} - (Q_W+1)'({{Q_W{1'b0}}, qe_next} * (Q_W+1)'(CHAN_FULL));
    end

    always_comb begin
        res = (rem_reg >= REM_W'(CHAN_FULL)) ? qe_reg + COORD_W'(1) : qe_reg;
        if (res > COORD_W'(ONE_Q16)) begin
            res = COORD_W'(ONE_Q16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg  <= top_next;
        bot_reg  <= bot_next;
        wv_reg   <= in_sample.wv;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        qe_reg   <= qe_next;
        rem_reg  <= rem_full[REM_W-1:0];
    end

    assign out_valid     = v4_reg;
    assign out_intensity = res;

endmodule

// ----- rtl/core/bis_checker.sv -----
// Port-level checks of the bilinear intensity sampler and their bind.
// Depends on bis_pkg; attaches to bilinear_intensity_sampler.
module bis_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_kind,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bis_pkg::COORD_W-1:0]   m_intensity
);
    import bis_pkg::*;

    logic [7:0] pending_reg, pending_next;
    logic       q_in, r_out;

    always_comb begin
        q_in         = s_valid && s_ready && s_kind == KIND_QUERY;
        r_out        = m_valid && m_ready;
        pending_next = pending_reg;
        if (q_in && !r_out) begin
            pending_next = pending_reg + 8'd1;
        end else if (!q_in && r_out) begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 8'd0)
        else $error("result without an outstanding query");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_intensity <= COORD_W'(ONE_Q16))
        else $error("intensity above full scale");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_intensity))
        else $error("result changed while stalled");

endmodule

bind bilinear_intensity_sampler bis_checker u_bis_checker (.*);

// ----- test/bilinear_intensity_sampler_tb.sv -----
// Testbench for the bilinear intensity sampler: a directed table of pixel writes and
// queries, then randomized traffic over several image sizes, checked against an
// in-bench bilinear predictor. Depends on bis_pkg and the sampler RTL.
module bilinear_intensity_sampler_tb;
    import bis_pkg::*;

    localparam int MAX_W          = 256;
    localparam int MAX_H          = 256;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 2000000;
    localparam int DIRECTED_ROWS  = 14;

    localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   pixel_index;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [COORD_W-1:0]  u_coord;
        logic [COORD_W-1:0]  v_coord;
        logic                has_golden;
        logic [COORD_W-1:0]  golden;
    } stim_row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]     cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_kind        = 1'b0;
    logic [ADDR_W-1:0]    s_pixel_index = '0;
    logic [7:0]           s_red         = '0;
    logic [7:0]           s_green       = '0;
    logic [7:0]           s_blue        = '0;
    logic [COORD_W-1:0]   s_u_coord     = '0;
    logic [COORD_W-1:0]   s_v_coord     = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [COORD_W-1:0]   m_intensity;

    logic [SUM_W-1:0]     pixel_sum [2**ADDR_W];
    bit                   pixel_written [2**ADDR_W];
    logic [CFG_W-1:0]     width_setting  = CFG_W'(CFG_RESET);
    logic [CFG_W-1:0]     height_setting = CFG_W'(CFG_RESET);
    logic [COORD_W-1:0]   expected_intensity_q [$];

    int unsigned error_count    = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen   = 0;
    bit          hold_request   = 1'b0;
    bit          no_idle        = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KIND_WRITE, 16'd0,     8'd0,   8'd0,   8'd0,   17'h1FFFF, 17'h1FFFF, 1'b0, 17'd0},
        '{KIND_WRITE, 16'd1,     8'd255, 8'd255, 8'd255, 17'd0,     17'd0,     1'b0, 17'd0},
        '{KIND_WRITE, 16'd256,   8'd255, 8'd0,   8'd0,   17'd0,     17'd0,     1'b0, 17'd0},
        '{KIND_WRITE, 16'd257,   8'd0,   8'd255, 8'd255, 17'd0,     17'd0,     1'b0, 17'd0},
        '{KIND_WRITE, 16'hFFFF,  8'd255, 8'd255, 8'd255, 17'd0,     17'd0,     1'b0, 17'd0},
        '{KIND_QUERY, 16'hFFFF,  8'd255, 8'd255, 8'd255, 17'd0,     17'd0,     1'b1, 17'd0},
        '{KIND_QUERY, 16'd0,     8'd0,   8'd0,   8'd0,   17'd128,   17'd0,     1'b1, 17'd32768},
        '{KIND_QUERY, 16'd0,     8'd0,   8'd0,   8'd0,   17'd0,     17'd128,   1'b0, 17'd0},
        '{KIND_QUERY, 16'd0,     8'd0,   8'd0,   8'd0,   17'd128,   17'd128,   1'b1, 17'd32768},
        '{KIND_QUERY, 16'd0,     8'd0,   8'd0,   8'd0,   17'd65536, 17'd65536, 1'b1, 17'd65536},
        '{KIND_QUERY, 16'd0,     8'd0,   8'd0,   8'd0,   17'h1FFFF, 17'h1FFFF, 1'b1, 17'd65536},
        '{KIND_QUERY, 16'd0,     8'd0,   8'd0,   8'd0,   17'd1,     17'd0,     1'b0, 17'd0},
        '{KIND_WRITE, 16'hFFFF,  8'd0,   8'd0,   8'd0,   17'h1FFFF, 17'h1FFFF, 1'b0, 17'd0},
        '{KIND_QUERY, 16'd0,     8'd0,   8'd0,   8'd0,   17'd65536, 17'h1FFFF, 1'b1, 17'd0}
    };

    bilinear_intensity_sampler #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pixel_index (s_pixel_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_u_coord     (s_u_coord),
        .s_v_coord     (s_v_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_intensity   (m_intensity)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_error(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned used_size(logic [CFG_W-1:0] setting, int unsigned limit);
        if (setting == 0) return 1;
        if (setting > limit) return limit;
        return setting;
    endfunction

    function automatic void axis_span(input int unsigned size, input logic [COORD_W-1:0] coord,
                                      output int unsigned lo, output int unsigned hi,
                                      output longint unsigned weight);
        longint unsigned prod;
        longint unsigned whole;
        longint unsigned last;
        longint unsigned off;
        prod  = size;
        prod  = prod * coord;
        whole = prod >> 16;
        last  = size - 1;
        lo    = 32'((whole > last) ? last : whole);
        hi    = 32'((whole + 1 > last) ? last : whole + 1);
        off   = prod - (longint'(lo) << 16);
        weight = (off > ONE_Q16) ? ONE_Q16 : off;
    endfunction

    function automatic logic [ADDR_W-1:0] pixel_addr(int unsigned x, int unsigned y,
                                                     int unsigned w);
        return ADDR_W'(y * w + x);
    endfunction

    function automatic void locate(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                   output logic [3:0][ADDR_W-1:0] addr,
                                   output longint unsigned wu, output longint unsigned wv);
        int unsigned w;
        int unsigned h;
        int unsigned x0;
        int unsigned x1;
        int unsigned y0;
        int unsigned y1;
        w = used_size(width_setting, MAX_W);
        h = used_size(height_setting, MAX_H);
        axis_span(w, u, x0, x1, wu);
        axis_span(h, v, y0, y1, wv);
        addr[PH_00] = pixel_addr(x0, y0, w);
        addr[PH_10] = pixel_addr(x1, y0, w);
        addr[PH_01] = pixel_addr(x0, y1, w);
        addr[PH_11] = pixel_addr(x1, y1, w);
    endfunction

    function automatic logic [COORD_W-1:0] blend_intensity(logic [COORD_W-1:0] u,
                                                           logic [COORD_W-1:0] v);
        logic [3:0][ADDR_W-1:0] addr;
        longint unsigned wu;
        longint unsigned wv;
        longint unsigned top;
        longint unsigned bot;
        longint unsigned acc;
        longint unsigned res;
        locate(u, v, addr, wu, wv);
        top = pixel_sum[addr[PH_00]] * (ONE_Q16 - wu) + pixel_sum[addr[PH_10]] * wu;
        bot = pixel_sum[addr[PH_01]] * (ONE_Q16 - wu) + pixel_sum[addr[PH_11]] * wu;
        acc = top * (ONE_Q16 - wv) + bot * wv;
        res = (acc + ROUND_ADD) / (longint'(CHAN_FULL) * ONE_Q16);
        if (res > ONE_Q16) res = ONE_Q16;
        return COORD_W'(res);
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned pick;
        if (no_idle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] random_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return 8'h00;
        if (pick < 30) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 20) return COORD_W'(ONE_Q16);
        if (pick < 30) return COORD_W'($urandom_range(0, 2**COORD_W - 1));
        return COORD_W'($urandom_range(0, ONE_Q16));
    endfunction

    function automatic stim_row_t random_write();
        stim_row_t it;
        int unsigned w;
        int unsigned h;
        w = used_size(width_setting, MAX_W);
        h = used_size(height_setting, MAX_H);
        it.kind = KIND_WRITE;
        if ($urandom_range(0, 99) < 60)
            it.pixel_index = pixel_addr($urandom_range(0, w - 1), $urandom_range(0, h - 1), w);
        else
            it.pixel_index = ADDR_W'($urandom_range(0, 2**ADDR_W - 1));
        it.red        = random_byte();
        it.green      = random_byte();
        it.blue       = random_byte();
        it.u_coord    = COORD_W'($urandom_range(0, 2**COORD_W - 1));
        it.v_coord    = COORD_W'($urandom_range(0, 2**COORD_W - 1));
        it.has_golden = 1'b0;
        it.golden     = '0;
        return it;
    endfunction

    function automatic stim_row_t random_query();
        stim_row_t it;
        it.kind        = KIND_QUERY;
        it.pixel_index = ADDR_W'($urandom_range(0, 2**ADDR_W - 1));
        it.red         = random_byte();
        it.green       = random_byte();
        it.blue        = random_byte();
        it.u_coord     = random_coord();
        it.v_coord     = random_coord();
        it.has_golden  = 1'b0;
        it.golden      = '0;
        return it;
    endfunction

    task automatic send_item(stim_row_t it);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= it.kind;
        s_pixel_index <= it.pixel_index;
        s_red         <= it.red;
        s_green       <= it.green;
        s_blue        <= it.blue;
        s_u_coord     <= it.u_coord;
        s_v_coord     <= it.v_coord;
        do @(posedge aclk); while (!s_ready);
        items_accepted++;
    endtask

    task automatic write_pixel(stim_row_t it);
        send_item(it);
        pixel_sum[it.pixel_index]     = {2'b00, it.red} + {2'b00, it.green} + {2'b00, it.blue};
        pixel_written[it.pixel_index] = 1'b1;
    endtask

    // Fill any unwritten neighbor first so the query never reads undefined pixels.
    task automatic query_pixels(stim_row_t it);
        logic [3:0][ADDR_W-1:0] addr;
        longint unsigned wu;
        longint unsigned wv;
        stim_row_t fill;
        logic [COORD_W-1:0] expected;
        locate(it.u_coord, it.v_coord, addr, wu, wv);
        for (int n = 0; n < 4; n++) begin
            if (!pixel_written[addr[n]]) begin
                fill = random_write();
                fill.pixel_index = addr[n];
                write_pixel(fill);
            end
        end
        expected = it.has_golden ? it.golden : blend_intensity(it.u_coord, it.v_coord);
        send_item(it);
        expected_intensity_q.push_back(expected);
    endtask

    task automatic run_random(int unsigned budget, bit with_hold);
        int unsigned start;
        bit asked;
        start = items_accepted;
        asked = 1'b0;
        while (items_accepted - start < budget) begin
            if (with_hold && !asked && items_accepted - start >= 40) begin
                hold_request = 1'b1;
                asked = 1'b1;
            end
            if ($urandom_range(0, 99) < 3) no_idle = !no_idle;
            if ($urandom_range(0, 99) < 45) write_pixel(random_write());
            else query_pixels(random_query());
        end
        no_idle = 1'b0;
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_intensity_q.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_intensity_q.size() > 0) begin
            report_error($sformatf("%0d results never arrived", expected_intensity_q.size()));
            expected_intensity_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setting(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
        cfg_index <= index;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (index == REG_IMAGE_WIDTH) width_setting = value;
        else if (index == REG_IMAGE_HEIGHT) height_setting = value;
    endtask

    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        settle();
        write_setting(REG_IMAGE_WIDTH, w);
        write_setting(REG_IMAGE_HEIGHT, h);
    endtask

    initial begin : result_sink
        int unsigned run_len;
        int unsigned stall_len;
        int unsigned pick;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                run_len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 8)
                                                       : $urandom_range(40, 120);
                m_ready <= 1'b1;
                repeat (run_len) @(posedge aclk);
                pick = $urandom_range(0, 99);
                if (pick < 50) stall_len = 0;
                else if (pick < 90) stall_len = $urandom_range(1, 3);
                else stall_len = $urandom_range(20, 80);
                if (stall_len > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall_len) @(posedge aclk);
                end
            end
        end
    end

    initial begin : result_check
        logic [COORD_W-1:0] want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (expected_intensity_q.size() == 0) begin
                    report_error($sformatf("unexpected item, intensity %0d", m_intensity));
                end else begin
                    want = expected_intensity_q.pop_front();
                    if (m_intensity !== want)
                        report_error($sformatf("intensity %0d, want %0d (result %0d)",
                                               m_intensity, want, results_seen));
                end
            end
        end
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == KIND_WRITE) write_pixel(directed_rows[i]);
            else query_pixels(directed_rows[i]);
        end
        run_random(150, 1'b1);

        configure(9'd0, 9'd0);
        run_random(150, 1'b0);
        configure(9'd1, 9'd256);
        run_random(150, 1'b0);
        configure(9'd256, 9'd1);
        run_random(150, 1'b0);

        configure(9'd511, 9'd300);
        write_setting(REG_SPARE_2, 9'h1FF);
        write_setting(REG_SPARE_3, 9'h0AA);
        run_random(200, 1'b0);

        configure(9'd3, 9'd2);
        run_random(200, 1'b0);
        configure(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)));
        run_random(250, 1'b1);
        configure(CFG_W'($urandom_range(1, 256)), CFG_W'($urandom_range(1, 256)));
        run_random(200, 1'b0);
        configure(9'd256, 9'd256);
        run_random(200, 1'b0);

        settle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
